FILE: sv/mi3lu_pkg.sv
// Shared types, constants and fixed-point helpers for the 3x3 LU matrix inverse.
`default_nettype none
package mi3lu_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAT_N         = 9;

    typedef logic signed [DATA_W-1:0] fx_t;

    localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
    localparam fx_t FX_MIN = 32'sh8000_0000;

    function automatic fx_t sat_add(input fx_t x, input fx_t y);
        logic signed [DATA_W:0] s;
        s = {x[DATA_W-1], x} + {y[DATA_W-1], y};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? FX_MIN : FX_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic fx_t sat_sub(input fx_t x, input fx_t y);
        logic signed [DATA_W:0] s;
        s = {x[DATA_W-1], x} - {y[DATA_W-1], y};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? FX_MIN : FX_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic fx_t sat_neg(input fx_t x);
        return (x == FX_MIN) ? FX_MAX : -x;
    endfunction

    // Full product, scaled down with truncation toward zero, then saturated.
    function automatic fx_t fx_mul(input fx_t x, input fx_t y, input int frac);
        logic signed [2*DATA_W-1:0] p;
        logic signed [2*DATA_W-1:0] bias;
        logic signed [2*DATA_W-1:0] sh;
        p    = 64'(x) * 64'(y);
        bias = p[2*DATA_W-1] ? ((64'sd1 <<< frac) - 64'sd1) : 64'sd0;
        sh   = (p + bias) >>> frac;
        if (sh > 64'sd2147483647) begin
            return FX_MAX;
        end
        if (sh < -64'sd2147483648) begin
            return FX_MIN;
        end
        return sh[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/mi3lu_div.sv
// Pipelined fixed-point divider: one quotient bit per stage, shared divisor, side payload.
`default_nettype none
module mi3lu_div
    import mi3lu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int LANES     = 1,
    parameter int SIDE_W    = 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [LANES-1:0][DATA_W-1:0]   num,
    input  wire logic [DATA_W-1:0]              den,
    input  wire logic [SIDE_W-1:0]              side_in,
    output logic                                out_valid,
    output logic      [LANES-1:0][DATA_W-1:0]   quo,
    output logic      [SIDE_W-1:0]              side_out
);

    localparam int NB = DATA_W + FRAC_BITS;

    logic                           vld_reg  [0:NB];
    logic [LANES-1:0][NB-1:0]       nq_reg   [0:NB];
    logic [LANES-1:0][DATA_W-1:0]   rem_reg  [0:NB];
    logic [LANES-1:0]               neg_reg  [0:NB];
    logic [DATA_W-1:0]              dmag_reg [0:NB];
    logic [SIDE_W-1:0]              side_reg [0:NB];

    logic [LANES-1:0][NB-1:0]       nq_prep;
    logic [LANES-1:0]               neg_prep;
    logic [DATA_W-1:0]              dmag_prep;

    always_comb begin
        logic [DATA_W-1:0] nmag;
        dmag_prep = den[DATA_W-1] ? (~den + 1'b1) : den;
        for (int l = 0; l < LANES; l++) begin
            nmag        = num[l][DATA_W-1] ? (~num[l] + 1'b1) : num[l];
            nq_prep[l]  = {nmag, {FRAC_BITS{1'b0}}};
            neg_prep[l] = num[l][DATA_W-1] ^ den[DATA_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg[0]   <= nq_prep;
            rem_reg[0]  <= '0;
            neg_reg[0]  <= neg_prep;
            dmag_reg[0] <= dmag_prep;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= NB; k++) begin : g_step
        logic [LANES-1:0][NB-1:0]     nq_next;
        logic [LANES-1:0][DATA_W-1:0] rem_next;

        // Restoring step: bring in the next dividend bit, subtract when it fits.
        always_comb begin
            logic [DATA_W:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = {rem_reg[k-1][l], nq_reg[k-1][l][NB-1]};
                if (trial >= {1'b0, dmag_reg[k-1]}) begin
                    rem_next[l] = DATA_W'(trial - {1'b0, dmag_reg[k-1]});
                    nq_next[l]  = {nq_reg[k-1][l][NB-2:0], 1'b1};
                end else begin
                    rem_next[l] = trial[DATA_W-1:0];
                    nq_next[l]  = {nq_reg[k-1][l][NB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[k]   <= nq_next;
                rem_reg[k]  <= rem_next;
                neg_reg[k]  <= neg_reg[k-1];
                dmag_reg[k] <= dmag_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    logic [LANES-1:0][DATA_W-1:0] quo_next;
    logic                         out_vld_reg;
    logic [LANES-1:0][DATA_W-1:0] quo_reg;
    logic [SIDE_W-1:0]            side_out_reg;

    always_comb begin
        logic [NB-1:0] mag;
        for (int l = 0; l < LANES; l++) begin
            mag = nq_reg[NB][l];
            if (neg_reg[NB][l]) begin
                if ((|mag[NB-1:DATA_W]) || (mag[DATA_W-1:0] > 32'h8000_0000)) begin
                    quo_next[l] = FX_MIN;
                end else begin
                    quo_next[l] = ~mag[DATA_W-1:0] + 1'b1;
                end
            end else begin
                if ((|mag[NB-1:DATA_W]) || mag[DATA_W-1]) begin
                    quo_next[l] = FX_MAX;
                end else begin
                    quo_next[l] = mag[DATA_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[NB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg      <= quo_next;
            side_out_reg <= side_reg[NB];
        end
    end

    assign out_valid = out_vld_reg;
    assign quo       = quo_reg;
    assign side_out  = side_out_reg;

endmodule
`default_nettype wire

FILE: sv/matrix_inverse_3x3_lu.sv
// 3x3 matrix inverse: LU factorization, triangular inverses and their product, fully pipelined.
//
// One input beat on s_axis carries a whole 3x3 matrix of signed fixed-point entries
// (FRAC_BITS fraction bits) in s_tdata, a00 in the lowest 32 bits, row-major.
// One output beat on m_axis carries the inverse, row-major in m_tdata, and the
// singular flag in m_tuser. A zero pivot gives singular = 1 and an all-zero matrix;
// every other overflow saturates.
// Throughput is one matrix per cycle while m_axis is not stalled. The pipeline is built
// from three bit-serial division pipelines of 34+FRAC_BITS stages each, on a00, on U11
// and on U22, plus ten multiply and add stages.
// The pipeline moves as one: when m_tvalid is high and m_tready low, every stage
// holds and s_tready drops in the same cycle, so nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
`default_nettype none
module matrix_inverse_3x3_lu
    import mi3lu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [MAT_N*DATA_W-1:0] s_tdata,  // a00, a01, a02, a10, a11, a12, a20, a21, a22
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [MAT_N*DATA_W-1:0]      m_tdata,  // inv00, inv01, ..., inv22
    output logic [7:0]                   m_tuser   // singular, then zero fill
);

    localparam fx_t ONE   = fx_t'(64'sd1 <<< FRAC_BITS);
    localparam int  SIDE1 = 1 + 6*DATA_W;
    localparam int  SIDE2 = 1 + 8*DATA_W;
    localparam int  SIDE3 = 1 + 8*DATA_W;

    logic en;
    fx_t  a [MAT_N];

    always_comb begin
        for (int i = 0; i < MAT_N; i++) begin
            a[i] = s_tdata[i*DATA_W +: DATA_W];
        end
    end

    // ---- first division: l10, l20 and 1/a00 ----
    logic                         d1_vld;
    logic [2:0][DATA_W-1:0]       d1_quo;
    logic [SIDE1-1:0]             d1_side;
    logic                         d1_sing;
    fx_t d1_a01, d1_a02, d1_a11, d1_a12, d1_a21, d1_a22;

    mi3lu_div #(.FRAC_BITS(FRAC_BITS), .LANES(3), .SIDE_W(SIDE1)) u_div_a00 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .num      ({ONE, a[6], a[3]}),
        .den      (a[0]),
        .side_in  ({(a[0] == '0), a[1], a[2], a[4], a[5], a[7], a[8]}),
        .out_valid(d1_vld),
        .quo      (d1_quo),
        .side_out (d1_side)
    );

    assign {d1_sing, d1_a01, d1_a02, d1_a11, d1_a12, d1_a21, d1_a22} = d1_side;

    // ---- U row 1 and the partial row 2 ----
    logic b1_vld_reg, b1_sing_reg;
    fx_t  b1_l10_reg, b1_l20_reg, b1_v00_reg, b1_a01_reg, b1_a02_reg;
    fx_t  b1_a11_reg, b1_a12_reg, b1_a21_reg, b1_a22_reg;
    fx_t  b1_p0_reg, b1_p1_reg, b1_p2_reg, b1_p3_reg;

    logic b2_vld_reg, b2_sing_reg;
    fx_t  b2_l10_reg, b2_l20_reg, b2_v00_reg, b2_a01_reg, b2_a02_reg;
    fx_t  b2_u11_reg, b2_u12_reg, b2_t_reg, b2_w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg <= d1_vld;
            b2_vld_reg <= b1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_sing_reg <= d1_sing;
            b1_l10_reg  <= d1_quo[0];
            b1_l20_reg  <= d1_quo[1];
            b1_v00_reg  <= d1_quo[2];
            b1_a01_reg  <= d1_a01;
            b1_a02_reg  <= d1_a02;
            b1_a11_reg  <= d1_a11;
            b1_a12_reg  <= d1_a12;
            b1_a21_reg  <= d1_a21;
            b1_a22_reg  <= d1_a22;
            b1_p0_reg   <= fx_mul(d1_quo[0], d1_a01, FRAC_BITS);
            b1_p1_reg   <= fx_mul(d1_quo[0], d1_a02, FRAC_BITS);
            b1_p2_reg   <= fx_mul(d1_quo[1], d1_a01, FRAC_BITS);
            b1_p3_reg   <= fx_mul(d1_quo[1], d1_a02, FRAC_BITS);

            b2_sing_reg <= b1_sing_reg;
            b2_l10_reg  <= b1_l10_reg;
            b2_l20_reg  <= b1_l20_reg;
            b2_v00_reg  <= b1_v00_reg;
            b2_a01_reg  <= b1_a01_reg;
            b2_a02_reg  <= b1_a02_reg;
            b2_u11_reg  <= sat_sub(b1_a11_reg, b1_p0_reg);
            b2_u12_reg  <= sat_sub(b1_a12_reg, b1_p1_reg);
            b2_t_reg    <= sat_sub(b1_a21_reg, b1_p2_reg);
            b2_w_reg    <= sat_sub(b1_a22_reg, b1_p3_reg);
        end
    end

    // ---- second division: l21 and 1/u11 ----
    logic                   d2_vld;
    logic [1:0][DATA_W-1:0] d2_quo;
    logic [SIDE2-1:0]       d2_side;
    logic                   d2_sing;
    fx_t d2_l10, d2_l20, d2_v00, d2_a01, d2_a02, d2_u11, d2_u12, d2_w;

    mi3lu_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SIDE_W(SIDE2)) u_div_u11 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (b2_vld_reg),
        .num      ({ONE, b2_t_reg}),
        .den      (b2_u11_reg),
        .side_in  ({b2_sing_reg | (b2_u11_reg == '0), b2_l10_reg, b2_l20_reg, b2_v00_reg,
                    b2_a01_reg, b2_a02_reg, b2_u11_reg, b2_u12_reg, b2_w_reg}),
        .out_valid(d2_vld),
        .quo      (d2_quo),
        .side_out (d2_side)
    );

    assign {d2_sing, d2_l10, d2_l20, d2_v00, d2_a01, d2_a02, d2_u11, d2_u12, d2_w} = d2_side;

    // ---- U22 and the inverse of L ----
    logic c1_vld_reg, c1_sing_reg;
    fx_t  c1_l20_reg, c1_v00_reg, c1_a01_reg, c1_a02_reg, c1_u12_reg, c1_w_reg;
    fx_t  c1_v11_reg, c1_m10_reg, c1_m21_reg, c1_p_reg, c1_q_reg;

    logic c2_vld_reg, c2_sing_reg;
    fx_t  c2_v00_reg, c2_a01_reg, c2_a02_reg, c2_u12_reg, c2_v11_reg;
    fx_t  c2_m10_reg, c2_m20_reg, c2_m21_reg, c2_u22_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
        end else if (en) begin
            c1_vld_reg <= d2_vld;
            c2_vld_reg <= c1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_sing_reg <= d2_sing;
            c1_l20_reg  <= d2_l20;
            c1_v00_reg  <= d2_v00;
            c1_a01_reg  <= d2_a01;
            c1_a02_reg  <= d2_a02;
            c1_u12_reg  <= d2_u12;
            c1_w_reg    <= d2_w;
            c1_v11_reg  <= d2_quo[1];
            c1_m10_reg  <= sat_neg(d2_l10);
            c1_m21_reg  <= sat_neg(d2_quo[0]);
            c1_p_reg    <= fx_mul(d2_quo[0], d2_u12, FRAC_BITS);
            c1_q_reg    <= fx_mul(d2_quo[0], sat_neg(d2_l10), FRAC_BITS);

            c2_sing_reg <= c1_sing_reg;
            c2_v00_reg  <= c1_v00_reg;
            c2_a01_reg  <= c1_a01_reg;
            c2_a02_reg  <= c1_a02_reg;
            c2_u12_reg  <= c1_u12_reg;
            c2_v11_reg  <= c1_v11_reg;
            c2_m10_reg  <= c1_m10_reg;
            c2_m21_reg  <= c1_m21_reg;
            c2_m20_reg  <= sat_neg(sat_add(c1_l20_reg, c1_q_reg));
            c2_u22_reg  <= sat_sub(c1_w_reg, c1_p_reg);
        end
    end

    // ---- third division: 1/u22 ----
    logic                   d3_vld;
    logic [0:0][DATA_W-1:0] d3_quo;
    logic [SIDE3-1:0]       d3_side;
    logic                   d3_sing;
    fx_t d3_v00, d3_a01, d3_a02, d3_u12, d3_v11, d3_m10, d3_m20, d3_m21;

    mi3lu_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SIDE_W(SIDE3)) u_div_u22 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (c2_vld_reg),
        .num      (ONE),
        .den      (c2_u22_reg),
        .side_in  ({c2_sing_reg | (c2_u22_reg == '0), c2_v00_reg, c2_a01_reg, c2_a02_reg,
                    c2_u12_reg, c2_v11_reg, c2_m10_reg, c2_m20_reg, c2_m21_reg}),
        .out_valid(d3_vld),
        .quo      (d3_quo),
        .side_out (d3_side)
    );

    assign {d3_sing, d3_v00, d3_a01, d3_a02, d3_u12, d3_v11, d3_m10, d3_m20, d3_m21} = d3_side;

    // ---- inverse of U, then the product inv(U) * inv(L) ----
    logic e1_vld_reg, e1_sing_reg;
    fx_t  e1_v00_reg, e1_v11_reg, e1_v22_reg, e1_a01_reg;
    fx_t  e1_m10_reg, e1_m20_reg, e1_m21_reg, e1_p1_reg, e1_p2_reg, e1_p3_reg;

    logic e2_vld_reg, e2_sing_reg;
    fx_t  e2_v00_reg, e2_v11_reg, e2_v22_reg, e2_a01_reg, e2_p3_reg;
    fx_t  e2_m10_reg, e2_m20_reg, e2_m21_reg, e2_v01_reg, e2_v12_reg;

    logic e3_vld_reg, e3_sing_reg;
    fx_t  e3_v00_reg, e3_v11_reg, e3_v22_reg, e3_v01_reg, e3_v12_reg, e3_p3_reg;
    fx_t  e3_m10_reg, e3_m20_reg, e3_m21_reg, e3_p4_reg;

    logic e4_vld_reg, e4_sing_reg;
    fx_t  e4_v00_reg, e4_v11_reg, e4_v22_reg, e4_v01_reg, e4_v12_reg, e4_v02_reg;
    fx_t  e4_m10_reg, e4_m20_reg, e4_m21_reg;

    logic e5_vld_reg, e5_sing_reg;
    fx_t  e5_v00_reg, e5_v11_reg, e5_v22_reg, e5_v01_reg, e5_v12_reg, e5_v02_reg;
    fx_t  e5_t_reg [1:8];

    logic                    e6_vld_reg, e6_sing_reg;
    logic [MAT_N*DATA_W-1:0] e6_data_reg;
    logic [MAT_N*DATA_W-1:0] e6_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
            e4_vld_reg <= 1'b0;
            e5_vld_reg <= 1'b0;
            e6_vld_reg <= 1'b0;
        end else if (en) begin
            e1_vld_reg <= d3_vld;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
            e4_vld_reg <= e3_vld_reg;
            e5_vld_reg <= e4_vld_reg;
            e6_vld_reg <= e5_vld_reg;
        end
    end

    always_comb begin
        fx_t r [MAT_N];
        r[0] = sat_add(sat_add(e5_v00_reg, e5_t_reg[1]), e5_t_reg[2]);
        r[1] = sat_add(e5_v01_reg, e5_t_reg[3]);
        r[2] = e5_v02_reg;
        r[3] = sat_add(e5_t_reg[4], e5_t_reg[5]);
        r[4] = sat_add(e5_v11_reg, e5_t_reg[6]);
        r[5] = e5_v12_reg;
        r[6] = e5_t_reg[7];
        r[7] = e5_t_reg[8];
        r[8] = e5_v22_reg;
        for (int i = 0; i < MAT_N; i++) begin
            e6_data_next[i*DATA_W +: DATA_W] = e5_sing_reg ? '0 : r[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_sing_reg <= d3_sing;
            e1_v00_reg  <= d3_v00;
            e1_v11_reg  <= d3_v11;
            e1_v22_reg  <= d3_quo[0];
            e1_a01_reg  <= d3_a01;
            e1_m10_reg  <= d3_m10;
            e1_m20_reg  <= d3_m20;
            e1_m21_reg  <= d3_m21;
            e1_p1_reg   <= fx_mul(d3_a01, d3_v11, FRAC_BITS);
            e1_p2_reg   <= fx_mul(d3_u12, d3_quo[0], FRAC_BITS);
            e1_p3_reg   <= fx_mul(d3_a02, d3_quo[0], FRAC_BITS);

            e2_sing_reg <= e1_sing_reg;
            e2_v00_reg  <= e1_v00_reg;
            e2_v11_reg  <= e1_v11_reg;
            e2_v22_reg  <= e1_v22_reg;
            e2_a01_reg  <= e1_a01_reg;
            e2_p3_reg   <= e1_p3_reg;
            e2_m10_reg  <= e1_m10_reg;
            e2_m20_reg  <= e1_m20_reg;
            e2_m21_reg  <= e1_m21_reg;
            e2_v01_reg  <= sat_neg(fx_mul(e1_v00_reg, e1_p1_reg, FRAC_BITS));
            e2_v12_reg  <= sat_neg(fx_mul(e1_v11_reg, e1_p2_reg, FRAC_BITS));

            e3_sing_reg <= e2_sing_reg;
            e3_v00_reg  <= e2_v00_reg;
            e3_v11_reg  <= e2_v11_reg;
            e3_v22_reg  <= e2_v22_reg;
            e3_v01_reg  <= e2_v01_reg;
            e3_v12_reg  <= e2_v12_reg;
            e3_p3_reg   <= e2_p3_reg;
            e3_m10_reg  <= e2_m10_reg;
            e3_m20_reg  <= e2_m20_reg;
            e3_m21_reg  <= e2_m21_reg;
            e3_p4_reg   <= fx_mul(e2_a01_reg, e2_v12_reg, FRAC_BITS);

            e4_sing_reg <= e3_sing_reg;
            e4_v00_reg  <= e3_v00_reg;
            e4_v11_reg  <= e3_v11_reg;
            e4_v22_reg  <= e3_v22_reg;
            e4_v01_reg  <= e3_v01_reg;
            e4_v12_reg  <= e3_v12_reg;
            e4_m10_reg  <= e3_m10_reg;
            e4_m20_reg  <= e3_m20_reg;
            e4_m21_reg  <= e3_m21_reg;
            e4_v02_reg  <= sat_neg(fx_mul(e3_v00_reg, sat_add(e3_p4_reg, e3_p3_reg),
                                          FRAC_BITS));

            e5_sing_reg <= e4_sing_reg;
            e5_v00_reg  <= e4_v00_reg;
            e5_v11_reg  <= e4_v11_reg;
            e5_v22_reg  <= e4_v22_reg;
            e5_v01_reg  <= e4_v01_reg;
            e5_v12_reg  <= e4_v12_reg;
            e5_v02_reg  <= e4_v02_reg;
            e5_t_reg[1] <= fx_mul(e4_v01_reg, e4_m10_reg, FRAC_BITS);
            e5_t_reg[2] <= fx_mul(e4_v02_reg, e4_m20_reg, FRAC_BITS);
            e5_t_reg[3] <= fx_mul(e4_v02_reg, e4_m21_reg, FRAC_BITS);
            e5_t_reg[4] <= fx_mul(e4_v11_reg, e4_m10_reg, FRAC_BITS);
            e5_t_reg[5] <= fx_mul(e4_v12_reg, e4_m20_reg, FRAC_BITS);
            e5_t_reg[6] <= fx_mul(e4_v12_reg, e4_m21_reg, FRAC_BITS);
            e5_t_reg[7] <= fx_mul(e4_v22_reg, e4_m20_reg, FRAC_BITS);
            e5_t_reg[8] <= fx_mul(e4_v22_reg, e4_m21_reg, FRAC_BITS);

            e6_sing_reg <= e5_sing_reg;
            e6_data_reg <= e6_data_next;
        end
    end

    // The whole pipeline advances unless a finished beat is waiting at the output.
    assign en       = !e6_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = e6_vld_reg;
    assign m_tdata  = e6_data_reg;
    assign m_tuser  = {7'b0, e6_sing_reg};

`ifndef SYNTH
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("singular beat carries nonzero data");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_zero_pivot: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && b1_vld_reg && (b1_v00_reg == '0) && !b1_sing_reg) |-> 1'b0)
        else $error("reciprocal of a nonzero pivot came out zero");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the 3x3 LU matrix inverse pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import mi3lu_pkg::*;

    typedef fx_t matrix_t [MAT_N];

    typedef struct {
        fx_t inv [MAT_N];
        bit  singular;
    } inverse_t;

    class inverse_scoreboard;
        inverse_t expected_q [$];
        int       errors;
        int       checked;
        int       singular_seen;

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint qadd(longint x, longint y);
            return sat(x + y);
        endfunction

        function longint qsub(longint x, longint y);
            return sat(x - y);
        endfunction

        function longint qneg(longint x);
            return sat(-x);
        endfunction

        // Division of longint truncates toward zero, as the block does.
        function longint qmul(longint x, longint y);
            return sat((x * y) / (64'sd1 <<< FRAC_BITS_DEF));
        endfunction

        function longint qdiv(longint x, longint y);
            return sat((x * (64'sd1 <<< FRAC_BITS_DEF)) / y);
        endfunction

        function inverse_t invert(matrix_t m);
            longint a [MAT_N];
            longint r [MAT_N];
            longint one, l10, l20, l21, u11, u12, u22, m10, m20, m21;
            longint v00, v01, v02, v11, v12, v22;
            bit sing;
            inverse_t res;
            one = 64'sd1 <<< FRAC_BITS_DEF;
            sing = 0;
            l10 = 0; l20 = 0; l21 = 0; u11 = 0; u12 = 0; u22 = 0;
            foreach (m[i]) a[i] = longint'(m[i]);
            if (a[0] == 0) begin
                sing = 1;
            end else begin
                l10 = qdiv(a[3], a[0]);
                l20 = qdiv(a[6], a[0]);
                u11 = qsub(a[4], qmul(l10, a[1]));
                u12 = qsub(a[5], qmul(l10, a[2]));
                if (u11 == 0) begin
                    sing = 1;
                end else begin
                    l21 = qdiv(qsub(a[7], qmul(l20, a[1])), u11);
                    u22 = qsub(qsub(a[8], qmul(l20, a[2])), qmul(l21, u12));
                    if (u22 == 0) sing = 1;
                end
            end
            foreach (r[i]) r[i] = 0;
            if (!sing) begin
                m10 = qneg(l10);
                m21 = qneg(l21);
                m20 = qneg(qadd(l20, qmul(l21, m10)));
                v00 = qdiv(one, a[0]);
                v11 = qdiv(one, u11);
                v22 = qdiv(one, u22);
                v01 = qneg(qmul(v00, qmul(a[1], v11)));
                v12 = qneg(qmul(v11, qmul(u12, v22)));
                v02 = qneg(qmul(v00, qadd(qmul(a[1], v12), qmul(a[2], v22))));
                r[0] = qadd(qadd(v00, qmul(v01, m10)), qmul(v02, m20));
                r[1] = qadd(v01, qmul(v02, m21));
                r[2] = v02;
                r[3] = qadd(qmul(v11, m10), qmul(v12, m20));
                r[4] = qadd(v11, qmul(v12, m21));
                r[5] = v12;
                r[6] = qmul(v22, m20);
                r[7] = qmul(v22, m21);
                r[8] = v22;
            end
            foreach (r[i]) res.inv[i] = fx_t'(r[i]);
            res.singular = sing;
            return res;
        endfunction

        function void note_matrix(matrix_t m);
            expected_q.push_back(invert(m));
        endfunction

        function void check_inverse(logic [MAT_N*DATA_W-1:0] data, logic [7:0] user);
            inverse_t e;
            if (expected_q.size() == 0) begin
                $error("result beat with no matrix outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.singular) singular_seen++;
            for (int i = 0; i < MAT_N; i++) begin
                if (data[i*DATA_W +: DATA_W] !== e.inv[i]) begin
                    $error("inv%0d%0d expected %h actual %h", i / 3, i % 3, e.inv[i],
                           data[i*DATA_W +: DATA_W]);
                    errors++;
                end
            end
            if (user[0] !== e.singular) begin
                $error("singular expected %b actual %b", e.singular, user[0]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    localparam int LATENCY     = 3 * (32 + FRAC_BITS_DEF) + 16;
    localparam int NUM_RANDOM  = 830;
    localparam int CYCLE_LIMIT = 400000;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [MAT_N*DATA_W-1:0] s_tdata;  // a00, a01, a02, a10, a11, a12, a20, a21, a22
    logic                    m_tvalid;
    logic                    m_tready;
    logic [MAT_N*DATA_W-1:0] m_tdata;  // inv00, inv01, ..., inv22
    logic [7:0]              m_tuser;  // singular, then zero fill

    inverse_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  cycles;
    int  sent;

    matrix_inverse_3x3_lu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random back-pressure and checking of every accepted beat.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_inverse(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_matrix(matrix_t m);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        for (int i = 0; i < MAT_N; i++) s_tdata[i*DATA_W +: DATA_W] <= m[i];
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_matrix(m);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic fx_t fx_int(int v);
        return fx_t'(v <<< FRAC_BITS_DEF);
    endfunction

    function automatic fx_t rand_span(int span);
        return fx_t'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic matrix_t diag_matrix(fx_t d0, fx_t d1, fx_t d2);
        matrix_t m;
        foreach (m[i]) m[i] = '0;
        m[0] = d0; m[4] = d1; m[8] = d2;
        return m;
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        int kind;
        kind = $urandom_range(9);
        foreach (m[i]) begin
            if (kind <= 5) m[i] = rand_span(4 << FRAC_BITS_DEF);
            else if (kind <= 7) m[i] = fx_int($urandom_range(4) - 2);
            else m[i] = fx_t'($urandom);
            if (kind == 9 && $urandom_range(2) == 0) m[i] = '0;
        end
        // Well-conditioned matrices get a heavy diagonal most of the time.
        if (kind <= 4) begin
            m[0] = m[0] + fx_int(8);
            m[4] = m[4] + fx_int(8);
            m[8] = m[8] + fx_int(8);
        end
        return m;
    endfunction

    initial begin
        matrix_t m;
        sb = new();
        cycles = 0;
        sent = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 54;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed matrices: identity, scaled diagonals, each zero pivot, extremes.
        send_matrix(diag_matrix(fx_int(1), fx_int(1), fx_int(1)));
        send_matrix(diag_matrix(fx_int(2), fx_int(-4), 32'sh0000_8000));
        send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag_matrix(FX_MAX, FX_MIN, FX_MAX));
        send_matrix(diag_matrix(FX_MIN, FX_MIN, FX_MIN));
        send_matrix(diag_matrix(-32'sd1, fx_int(1), -32'sd1));
        m = diag_matrix(fx_int(1), fx_int(1), fx_int(1));
        m[0] = '0;
        send_matrix(m);
        m = '{fx_int(1), fx_int(2), fx_int(3), fx_int(2), fx_int(4), fx_int(1),
              fx_int(1), fx_int(5), fx_int(2)};
        send_matrix(m);
        m = '{fx_int(1), fx_int(2), fx_int(3), fx_int(4), fx_int(5), fx_int(6),
              fx_int(7), fx_int(8), fx_int(9)};
        send_matrix(m);
        m = '{fx_int(2), fx_int(-1), '0, fx_int(-1), fx_int(2), fx_int(-1),
              '0, fx_int(-1), fx_int(2)};
        send_matrix(m);
        foreach (m[i]) m[i] = FX_MAX;
        send_matrix(m);
        foreach (m[i]) m[i] = FX_MIN;
        send_matrix(m);
        foreach (m[i]) m[i] = (i % 2) ? FX_MIN : FX_MAX;
        send_matrix(m);
        foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sd1 : FX_MAX;
        send_matrix(m);
        foreach (m[i]) m[i] = (i % 4 == 0) ? FX_MAX : 32'sd1;
        send_matrix(m);
        m = '{fx_int(1), FX_MAX, FX_MIN, FX_MAX, fx_int(1), FX_MAX, FX_MIN, FX_MAX,
              fx_int(1)};
        send_matrix(m);
        foreach (m[i]) m[i] = '0;
        send_matrix(m);
        foreach (m[i]) m[i] = -32'sd1;
        send_matrix(m);
        m = '{fx_int(3), fx_int(1), fx_int(-2), fx_int(-6), fx_int(4), fx_int(7),
              fx_int(9), fx_int(-3), fx_int(5)};
        send_matrix(m);
        wait_drained();

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 3) begin
                send_idle_pct = 54;
                recv_idle_pct = 16;
            end else if (n == 2 * NUM_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_matrix(random_matrix());
        end
        wait_drained();
        repeat (LATENCY + 20) @(posedge aclk);

        $display("Sent %0d matrices, checked %0d inverses, %0d of them singular.",
                 sent, sb.checked, sb.singular_seen);
        $display("Covered pivot failures, saturation extremes and three idle profiles.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
